### hdl/register_program_bitbang_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Register programming bit-bang encoder: assertion macros
// Shared concurrent assertion forms, synchronous reset disables checking.
// ----------------------------------------------------------------------------
`ifndef REGISTER_PROGRAM_BITBANG_ENCODER_UNIT_DEFINES_SVH
`define REGISTER_PROGRAM_BITBANG_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define RPBE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RPBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/rpbe_pkg.sv
// ----------------------------------------------------------------------------
// rpbe_pkg
// Types, codes and constants of the register programming bit-bang encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpbe_pkg;

   // field widths
   localparam int HDR_BITS   = 13;   // chip id, address, direction code
   localparam int DATA_W     = 34;
   localparam int CNT_W      = 6;
   localparam int CSR_DATA_W = 5;

   localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HDR_BITS - 1);

   // data bit counts per register slot
   localparam logic [CNT_W-1:0] NBITS_STD    = 6'd8;
   localparam logic [CNT_W-1:0] NBITS_GAIN   = 6'd10;
   localparam logic [CNT_W-1:0] NBITS_SELECT = 6'd4;
   localparam logic [CNT_W-1:0] NBITS_INJECT = 6'd34;

   // special register slots
   localparam logic [3:0] REG_INDEX_GAIN   = 4'd10;
   localparam logic [3:0] REG_INDEX_SELECT = 4'd11;
   localparam logic [3:0] REG_INDEX_UNUSED = 4'd12;
   localparam logic [3:0] REG_INDEX_INJECT = 4'd13;

   // config reset values
   localparam logic [4:0] CHIP_ID_RST    = 5'd10;
   localparam logic [2:0] READ_CODE_RST  = 3'd4;
   localparam logic [2:0] WRITE_CODE_RST = 3'd1;

   // waveform words: bit0 control, bit1 clock, bit2 data, bit3 reset
   localparam logic [3:0] WORD_ZERO     = 4'h0;
   localparam logic [3:0] WORD_CTRL     = 4'h1;
   localparam logic [3:0] WORD_CLK      = 4'h2;
   localparam logic [3:0] WORD_CLK_CTRL = 4'h3;

   localparam logic [1:0] COUNT_ONE = 2'd1;
   localparam logic [1:0] COUNT_TWO = 2'd2;

   typedef enum logic [1:0] {
      CSR_READ_MODE,
      CSR_CHIP_ID,
      CSR_READ_CODE,
      CSR_WRITE_CODE
   } csr_index_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_LEAD,
      SEQ_HDR,
      SEQ_SYNC,
      SEQ_DATA,
      SEQ_TAIL0,
      SEQ_TAIL1,
      SEQ_TAIL2,
      SEQ_END
   } seq_state_type;

   typedef struct packed {
      logic        start_frame;
      logic [3:0]  reg_index;
      logic [33:0] primary_value;
      logic [3:0]  secondary_value;
   } req_type;

   typedef struct packed {
      logic [3:0] word_first;
      logic [3:0] word_second;
      logic [1:0] word_count;
      logic       last;
   } rsp_type;

   // sequencer start command
   typedef struct packed {
      logic             start;
      logic             pad;
      logic [CNT_W-1:0] nbits;
   } seq_cmd_type;

   // shift register strobes
   typedef struct packed {
      logic load;
      logic hdr_shift;
      logic data_shift;
   } shift_ctrl_type;

   // a serialized bit is a clock-high word then a clock-low word
   function automatic logic [3:0] bit_word_first(input logic d);
      return WORD_CLK_CTRL | {1'b0, d, 2'b00};
   endfunction

   function automatic logic [3:0] bit_word_second(input logic d);
      return WORD_CTRL | {1'b0, d, 2'b00};
   endfunction

endpackage

### hdl/rpbe_shift.sv
// ----------------------------------------------------------------------------
// rpbe_shift
// Header and data shift registers; header leaves MSB first, data LSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpbe_shift (
   input  logic                        clock,
   input  rpbe_pkg::shift_ctrl_type    shift,
   input  logic [rpbe_pkg::HDR_BITS-1:0] hdr_load,
   input  logic [rpbe_pkg::DATA_W-1:0]   data_load,
   output logic                        hdr_bit,
   output logic                        data_bit
);

   logic [rpbe_pkg::HDR_BITS-1:0] hdr_ff, hdr_in;
   logic [rpbe_pkg::DATA_W-1:0]   data_ff, data_in;

   // next contents: load or shift one bit
   always_comb begin
      hdr_in  = hdr_ff;
      data_in = data_ff;
      if (shift.load) begin
         hdr_in  = hdr_load;
         data_in = data_load;
      end else begin
         if (shift.hdr_shift) begin
            hdr_in = {hdr_ff[rpbe_pkg::HDR_BITS-2:0], 1'b0};
         end
         if (shift.data_shift) begin
            data_in = {1'b0, data_ff[rpbe_pkg::DATA_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff  <= hdr_in;
      data_ff <= data_in;
   end

   assign hdr_bit  = hdr_ff[rpbe_pkg::HDR_BITS-1];
   assign data_bit = data_ff[0];

endmodule

### hdl/rpbe_ctrl.sv
// ----------------------------------------------------------------------------
// rpbe_ctrl
// Word-pair sequencer: walks lead, header, sync, data and tail phases,
// one result per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "register_program_bitbang_encoder_unit_defines.svh"

module rpbe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  rpbe_pkg::seq_cmd_type    cmd,
   input  logic                     advance,
   input  logic                     hdr_bit,
   input  logic                     data_bit,
   output rpbe_pkg::shift_ctrl_type shift,
   output logic                     fire,
   output logic                     busy,
   output rpbe_pkg::rsp_type        word
);

   rpbe_pkg::seq_state_type state_ff, state_in;
   logic [rpbe_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [rpbe_pkg::CNT_W-1:0] nbits_ff, nbits_in;
   logic pad_ff, pad_in;

   // next state and bit counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      nbits_in = nbits_ff;
      pad_in   = pad_ff;
      case (state_ff)
         rpbe_pkg::SEQ_IDLE: begin
            if (cmd.start) begin
               state_in = rpbe_pkg::SEQ_LEAD;
               nbits_in = cmd.nbits;
               pad_in   = cmd.pad;
            end
         end
         rpbe_pkg::SEQ_LEAD: begin
            if (advance) begin
               state_in = rpbe_pkg::SEQ_HDR;
               cnt_in   = rpbe_pkg::HDR_LAST;
            end
         end
         rpbe_pkg::SEQ_HDR: begin
            if (advance) begin
               if (cnt_ff == '0) begin
                  state_in = rpbe_pkg::SEQ_SYNC;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         rpbe_pkg::SEQ_SYNC: begin
            if (advance) begin
               state_in = rpbe_pkg::SEQ_DATA;
               cnt_in   = nbits_ff - 1'b1;
            end
         end
         rpbe_pkg::SEQ_DATA: begin
            if (advance) begin
               if (cnt_ff == '0) begin
                  state_in = rpbe_pkg::SEQ_TAIL0;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         rpbe_pkg::SEQ_TAIL0: begin
            if (advance) state_in = rpbe_pkg::SEQ_TAIL1;
         end
         rpbe_pkg::SEQ_TAIL1: begin
            if (advance) state_in = rpbe_pkg::SEQ_TAIL2;
         end
         rpbe_pkg::SEQ_TAIL2: begin
            if (advance) state_in = rpbe_pkg::SEQ_END;
         end
         rpbe_pkg::SEQ_END: begin
            if (advance) state_in = rpbe_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = rpbe_pkg::SEQ_IDLE;
         end
      endcase
   end

   // word pair, strobes and handshake
   always_comb begin
      busy             = (state_ff != rpbe_pkg::SEQ_IDLE);
      fire             = busy && advance;
      shift.load       = cmd.start;
      shift.hdr_shift  = (state_ff == rpbe_pkg::SEQ_HDR) && advance;
      shift.data_shift = (state_ff == rpbe_pkg::SEQ_DATA) && advance;
      word.word_first  = rpbe_pkg::WORD_ZERO;
      word.word_second = rpbe_pkg::WORD_ZERO;
      word.word_count  = rpbe_pkg::COUNT_TWO;
      word.last        = 1'b0;
      case (state_ff)
         rpbe_pkg::SEQ_LEAD: begin
            word.word_second = rpbe_pkg::WORD_CTRL;
         end
         rpbe_pkg::SEQ_HDR: begin
            word.word_first  = rpbe_pkg::bit_word_first(hdr_bit);
            word.word_second = rpbe_pkg::bit_word_second(hdr_bit);
         end
         rpbe_pkg::SEQ_SYNC: begin
            word.word_first  = rpbe_pkg::WORD_CLK_CTRL;
            word.word_second = rpbe_pkg::WORD_CTRL;
         end
         rpbe_pkg::SEQ_DATA: begin
            word.word_first  = rpbe_pkg::bit_word_first(data_bit);
            word.word_second = rpbe_pkg::bit_word_second(data_bit);
         end
         rpbe_pkg::SEQ_TAIL0: begin
            word.word_first = rpbe_pkg::WORD_CTRL;
         end
         rpbe_pkg::SEQ_TAIL1, rpbe_pkg::SEQ_TAIL2: begin
            word.word_first = rpbe_pkg::WORD_CLK;
         end
         rpbe_pkg::SEQ_END: begin
            // closing zero, plus the pad zero when the frame needs it
            word.word_count = pad_ff ? rpbe_pkg::COUNT_TWO : rpbe_pkg::COUNT_ONE;
            word.last       = 1'b1;
         end
         default: begin
            word.word_count = rpbe_pkg::COUNT_TWO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpbe_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      nbits_ff <= nbits_in;
      pad_ff   <= pad_in;
   end

   `RPBE_ASSERT_SAME(a_start_when_idle, clock, reset, cmd.start, state_ff == rpbe_pkg::SEQ_IDLE, "request started while sequencer busy")
   `RPBE_ASSERT_NEXT(a_end_to_idle, clock, reset, (state_ff == rpbe_pkg::SEQ_END) && advance, state_ff == rpbe_pkg::SEQ_IDLE, "sequencer did not finish after last result")
   `RPBE_ASSERT_SAME(a_data_cnt_range, clock, reset, state_ff == rpbe_pkg::SEQ_DATA, cnt_ff < nbits_ff, "data bit count out of range")

endmodule

### hdl/register_program_bitbang_encoder_unit.sv
// ----------------------------------------------------------------------------
// register_program_bitbang_encoder_unit
// The first result is registered from the lead phase after the request is taken.
// Throughput: 19 + n results, n = 8, 10, 4 or 34 data bits, one per cycle
// while the result channel does not stall; a request holds the block until
// its last result is issued. Requests that yield nothing start no sequence.
// Reset (synchronous, high) restores config defaults and clears frame parity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module register_program_bitbang_encoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rpbe_pkg::req_type                 req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rpbe_pkg::rsp_type                 rsp_data,
   // config write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  rpbe_pkg::csr_index_type           csr_index,
   input  logic [rpbe_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic       read_mode_ff;
   logic [4:0] chip_id_ff;
   logic [2:0] read_code_ff;
   logic [2:0] write_code_ff;
   logic       frame_odd_ff, frame_odd_in;

   logic                          accept;
   logic                          drop;
   logic [rpbe_pkg::DATA_W-1:0]   data_sel;
   logic [rpbe_pkg::CNT_W-1:0]    nbits_sel;
   logic [rpbe_pkg::HDR_BITS-1:0] hdr_sel;
   logic [4:0]                    addr;

   rpbe_pkg::seq_cmd_type    cmd;
   rpbe_pkg::shift_ctrl_type shift;
   rpbe_pkg::rsp_type        word;
   logic fire, busy, advance, hdr_bit, data_bit;

   logic              rsp_valid_ff;
   rpbe_pkg::rsp_type rsp_ff;

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_mode_ff  <= 1'b0;
         chip_id_ff    <= rpbe_pkg::CHIP_ID_RST;
         read_code_ff  <= rpbe_pkg::READ_CODE_RST;
         write_code_ff <= rpbe_pkg::WRITE_CODE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rpbe_pkg::CSR_READ_MODE:  read_mode_ff  <= csr_data[0];
            rpbe_pkg::CSR_CHIP_ID:    chip_id_ff    <= csr_data[4:0];
            rpbe_pkg::CSR_READ_CODE:  read_code_ff  <= csr_data[2:0];
            rpbe_pkg::CSR_WRITE_CODE: write_code_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // request decode: data layout, bit count, header
   always_comb begin
      case (req_data.reg_index)
         rpbe_pkg::REG_INDEX_GAIN: begin
            data_sel  = {24'd0, req_data.secondary_value, req_data.primary_value[5:0]};
            nbits_sel = rpbe_pkg::NBITS_GAIN;
         end
         rpbe_pkg::REG_INDEX_SELECT: begin
            data_sel  = {30'd0, req_data.secondary_value[1:0], req_data.primary_value[1:0]};
            nbits_sel = rpbe_pkg::NBITS_SELECT;
         end
         rpbe_pkg::REG_INDEX_INJECT: begin
            data_sel  = req_data.primary_value;
            nbits_sel = rpbe_pkg::NBITS_INJECT;
         end
         default: begin
            data_sel  = {26'd0, req_data.primary_value[7:0]};
            nbits_sel = rpbe_pkg::NBITS_STD;
         end
      endcase
      if (read_mode_ff) data_sel = '0;
   end

   assign addr    = {1'b0, req_data.reg_index} + 5'd1;
   assign hdr_sel = {chip_id_ff, addr, read_mode_ff ? read_code_ff : write_code_ff};

   // unused slot, out-of-range slot, inject slot in read mode: no results
   assign drop = (req_data.reg_index == rpbe_pkg::REG_INDEX_UNUSED)
              || (req_data.reg_index > rpbe_pkg::REG_INDEX_INJECT)
              || ((req_data.reg_index == rpbe_pkg::REG_INDEX_INJECT) && read_mode_ff);

   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   // request start; pad when the frame already holds an odd word count
   assign cmd.start = accept && !drop;
   assign cmd.pad   = frame_odd_ff && !req_data.start_frame;
   assign cmd.nbits = nbits_sel;

   // frame length parity
   always_comb begin
      frame_odd_in = frame_odd_ff;
      if (accept) begin
         if (!drop) begin
            frame_odd_in = 1'b1;
         end else if (req_data.start_frame) begin
            frame_odd_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_odd_ff <= 1'b0;
      end else begin
         frame_odd_ff <= frame_odd_in;
      end
   end

   rpbe_shift u_shift (
      .clock     (clock),
      .shift     (shift),
      .hdr_load  (hdr_sel),
      .data_load (data_sel),
      .hdr_bit   (hdr_bit),
      .data_bit  (data_bit)
   );

   rpbe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .advance  (advance),
      .hdr_bit  (hdr_bit),
      .data_bit (data_bit),
      .shift    (shift),
      .fire     (fire),
      .busy     (busy),
      .word     (word)
   );

   // result output register
   assign advance = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_ff <= word;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
